/* rtl/json_string_escaper_unit_assert.svh */
// Assertion macros used by the checker of the escaper.
`ifndef JSON_STRING_ESCAPER_UNIT_ASSERT_SVH
`define JSON_STRING_ESCAPER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define JSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("escaper check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define JSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("escaper check failed");

`endif

/* rtl/jse_pkg.sv */
package jse_pkg;

  localparam logic [15:0] CAPACITY_RESET = 16'd4096;
  localparam logic [15:0] MIN_CAPACITY   = 16'd2;
  localparam int          QUEUE_DEPTH_DEF = 2;

  localparam int SEQ_IDX_W = 3;

  localparam logic [7:0] CHR_QUOTE  = 8'h22;
  localparam logic [7:0] CHR_BSLASH = 8'h5c;
  localparam logic [7:0] CHR_BS     = 8'h08;
  localparam logic [7:0] CHR_FF     = 8'h0c;
  localparam logic [7:0] CHR_LF     = 8'h0a;
  localparam logic [7:0] CHR_CR     = 8'h0d;
  localparam logic [7:0] CHR_TAB    = 8'h09;
  localparam logic [7:0] CHR_LOW_B  = 8'h62;
  localparam logic [7:0] CHR_LOW_F  = 8'h66;
  localparam logic [7:0] CHR_LOW_N  = 8'h6e;
  localparam logic [7:0] CHR_LOW_R  = 8'h72;
  localparam logic [7:0] CHR_LOW_T  = 8'h74;
  localparam logic [7:0] CHR_LOW_U  = 8'h75;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  // Output length of each escape form.
  localparam logic [2:0] LEN_PLAIN   = 3'd1;
  localparam logic [2:0] LEN_SHORT   = 3'd2;
  localparam logic [2:0] LEN_UNICODE = 3'd6;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef enum logic [2:0] {
    CMD_PLAIN   = 3'd0,
    CMD_SHORT   = 3'd1,
    CMD_UNICODE = 3'd2,
    CMD_FAIL    = 3'd3,
    CMD_TERM    = 3'd4
  } cmd_kind_t;

  // One classified input byte on its way to the expander.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic [15:0] len;
    logic        fail;
  } cmd_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    return HEX_DIGITS[v];
  endfunction

endpackage

/* rtl/jse_front.sv */
module jse_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,
  input  logic         q_full,
  output logic         q_push,
  output jse_pkg::cmd_t q_cmd
);
  import jse_pkg::*;

  logic [15:0] capacity;
  logic [15:0] written_count;
  logic        overflow_flag;

  logic        accept;
  logic        is_term;
  logic        cap_low;
  logic        over;
  logic [2:0]  esc_len;
  logic [16:0] need;
  cmd_kind_t   esc_kind;
  logic [7:0]  esc_data;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign is_term  = (s_tdata == 8'h00);
  assign cap_low  = (capacity < MIN_CAPACITY);

  // Classify the byte into its escape form.
  always_comb begin
    esc_kind = CMD_SHORT;
    esc_data = s_tdata;
    esc_len  = LEN_SHORT;
    unique case (s_tdata)
      CHR_QUOTE:  esc_data = CHR_QUOTE;
      CHR_BSLASH: esc_data = CHR_BSLASH;
      CHR_BS:     esc_data = CHR_LOW_B;
      CHR_FF:     esc_data = CHR_LOW_F;
      CHR_LF:     esc_data = CHR_LOW_N;
      CHR_CR:     esc_data = CHR_LOW_R;
      CHR_TAB:    esc_data = CHR_LOW_T;
      default: begin
        if (s_tdata < CTRL_LIMIT) begin
          esc_kind = CMD_UNICODE;
          esc_len  = LEN_UNICODE;
        end else begin
          esc_kind = CMD_PLAIN;
          esc_len  = LEN_PLAIN;
        end
      end
    endcase
  end

  // Room check: count + escape + terminator must fit the capacity.
  assign need = {1'b0, written_count} + {14'd0, esc_len} + 17'd1;
  assign over = cap_low || (need > {1'b0, capacity});

  always_comb begin
    q_cmd      = '0;
    q_cmd.kind = esc_kind;
    q_cmd.data = esc_data;
    if (is_term) begin
      q_cmd.kind = CMD_TERM;
      q_cmd.fail = overflow_flag || cap_low;
      q_cmd.len  = (overflow_flag || cap_low) ? 16'd0 : written_count;
    end else if (over) begin
      q_cmd.kind = CMD_FAIL;
      q_cmd.fail = 1'b1;
    end
  end

  // Drop bytes of a failed string; everything else goes to the queue.
  assign q_push = accept && (is_term || !overflow_flag);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAPACITY_RESET;
      written_count <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        if (is_term) begin
          written_count <= '0;
          overflow_flag <= 1'b0;
        end else if (!overflow_flag) begin
          if (over) begin
            overflow_flag <= 1'b1;
          end else begin
            written_count <= written_count + {13'd0, esc_len};
          end
        end
      end
    end
  end

endmodule

/* rtl/jse_queue.sv */
module jse_queue #(
  parameter int DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jse_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output jse_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import jse_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/jse_back.sv */
module jse_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  output logic          q_pop,
  input  jse_pkg::cmd_t q_cmd,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [23:0]   m_tdata,
  output logic          m_tlast,
  output logic [1:0]    m_tuser
);
  import jse_pkg::*;

  cmd_t                 cur;
  logic                 cur_valid;
  logic [SEQ_IDX_W-1:0] idx;

  logic [7:0]  out_byte;
  logic [15:0] out_len;
  logic        out_done;
  logic        out_fail;

  logic [7:0]  e_byte;
  logic [15:0] e_len;
  logic        e_last;
  logic        e_done;
  logic        e_fail;

  logic slot_free;
  logic advance;
  logic cur_free;

  // Produce the byte at position idx of the current command's expansion.
  always_comb begin
    e_byte = 8'h00;
    e_len  = 16'd0;
    e_last = 1'b1;
    e_done = 1'b0;
    e_fail = 1'b0;
    unique case (cur.kind)
      CMD_PLAIN: e_byte = cur.data;
      CMD_SHORT: begin
        e_byte = (idx == '0) ? CHR_BSLASH : cur.data;
        e_last = (idx == SEQ_IDX_W'(LEN_SHORT - 3'd1));
      end
      CMD_UNICODE: begin
        e_last = (idx == SEQ_IDX_W'(LEN_UNICODE - 3'd1));
        case (idx)
          3'd0:    e_byte = CHR_BSLASH;
          3'd1:    e_byte = CHR_LOW_U;
          3'd2:    e_byte = CHR_ZERO;
          3'd3:    e_byte = CHR_ZERO;
          3'd4:    e_byte = hex_digit(cur.data[7:4]);
          default: e_byte = hex_digit(cur.data[3:0]);
        endcase
      end
      CMD_FAIL: e_fail = 1'b1;
      CMD_TERM: begin
        e_done = 1'b1;
        e_fail = cur.fail;
        e_len  = cur.len;
      end
      default: e_byte = 8'h00;
    endcase
  end

  assign slot_free = !m_tvalid || m_tready;
  assign advance   = cur_valid && slot_free;
  assign cur_free  = !cur_valid || (advance && e_last);
  assign q_pop     = !q_empty && cur_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      m_tvalid  <= 1'b0;
      idx       <= '0;
    end else begin
      if (slot_free) begin
        m_tvalid <= cur_valid;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (advance) begin
        if (e_last) begin
          cur_valid <= 1'b0;
        end else begin
          idx <= idx + SEQ_IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
    if (advance) begin
      out_byte <= e_byte;
      out_len  <= e_len;
      m_tlast  <= e_last;
      out_done <= e_done;
      out_fail <= e_fail;
    end
  end

  assign m_tdata = {out_len, out_byte};
  assign m_tuser = {out_fail, out_done};

endmodule

/* rtl/json_string_escaper_unit.sv */
// An accepted input byte passes the queue, the current-command register and the output
// register before its first result shows on m_*. One input byte per cycle for plain
// bytes while m_tready holds; a short escape gives 2 results and a \u00XX escape 6.
// Reset (rst, synchronous, active high) empties the queue and output register,
// sets capacity to 4096 and clears the byte count and failure flag.
module json_string_escaper_unit #(
  parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // capacity register write
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // source bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  // escaped bytes
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] out_length
  output logic        m_tlast,   // run_last: last result of one source byte
  output logic [1:0]  m_tuser    // [0] string_done, [1] failed
);
  import jse_pkg::*;

  // Front classifies each byte and tracks the length budget; the queue
  // decouples it from the back, which expands escapes one byte per
  // transaction into the output register.
  cmd_t q_in;
  cmd_t q_out;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  jse_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  // Hold classified commands while the back is busy with a long escape.
  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_out),
    .empty    (q_empty)
  );

  // Advance through each command's expansion as the sink takes results.
  jse_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_cmd    (q_out),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

/* rtl/jse_checker.sv */
`include "json_string_escaper_unit_assert.svh"

module jse_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast,
  input logic [1:0]  m_tuser
);

  // A terminator always closes the run of its source byte.
  `JSE_ASSERT_NOW(a_done_is_last, m_tvalid && m_tuser[0], m_tlast)

  // Failure results carry neither a byte nor a length.
  `JSE_ASSERT_NOW(a_fail_clean, m_tvalid && m_tuser[1], m_tdata == 24'd0)

  // Only a terminator reports a length.
  `JSE_ASSERT_NOW(a_len_on_done, m_tvalid && !m_tuser[0], m_tdata[23:8] == 16'd0)

  // Hold a stalled transaction.
  `JSE_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

endmodule

bind json_string_escaper_unit jse_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
